@@ hdl/morse_farnsworth_keyer_macros.svh @@
// Assertion helpers shared by the keyer RTL.
// Every check samples on the rising edge of clk and is off while rst_n is low.
`ifndef MORSE_FARNSWORTH_KEYER_MACROS_SVH
`define MORSE_FARNSWORTH_KEYER_MACROS_SVH

// Checks a property on every rising edge of clk.
`define MFK_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define MFK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    `MFK_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

@@ hdl/mfk_pkg.sv @@
`timescale 1ns / 1ps

package mfk_pkg;

    localparam int CHAR_W      = 8;
    localparam int WPM_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int UNIT_W      = 11;
    localparam int DUR_W       = 14;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_OVERALL_WPM = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_WPM    = 2'd1;

    localparam logic [WPM_W-1:0] OVERALL_WPM_RESET = 5'd9;
    localparam logic [WPM_W-1:0] CHAR_WPM_RESET    = 5'd18;

    // Code byte: bits 2:0 hold the element count, bit 3+i is element i (1 = dash).
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h12, 8'h0C, 8'h2C, 8'h0B, 8'h01, 8'h24, 8'h1B, 8'h04, 8'h02, 8'h74,
        8'h2B, 8'h14, 8'h1A, 8'h0A, 8'h3B, 8'h34, 8'h5C, 8'h13, 8'h03, 8'h09,
        8'h23, 8'h44, 8'h33, 8'h4C, 8'h6C, 8'h1C
    };
    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hFD, 8'hF5, 8'hE5, 8'hC5, 8'h85, 8'h05, 8'h0D, 8'h1D, 8'h3D, 8'h7D
    };
    localparam logic [7:0] CODE_SPACE = 8'hF8;
    localparam logic [7:0] CODE_HASH  = 8'h54;
    localparam logic [7:0] CODE_AT    = 8'h64;
    localparam logic [7:0] CODE_NONE  = 8'h00;
    localparam logic [2:0] MAX_ELEMS  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELEM,
        ST_GAP,
        ST_TAIL
    } seq_state_t;

    typedef enum logic [1:0] {
        SCALE_X1,
        SCALE_X3,
        SCALE_X7
    } scale_t;

    // One unit in milliseconds: 1200 / clamp(wpm, 1, 18), truncated.
    function automatic logic [UNIT_W-1:0] unit_ms(input logic [WPM_W-1:0] wpm);
        logic [UNIT_W-1:0] u;
        case (wpm)
            5'd0, 5'd1: u = 11'd1200;
            5'd2:       u = 11'd600;
            5'd3:       u = 11'd400;
            5'd4:       u = 11'd300;
            5'd5:       u = 11'd240;
            5'd6:       u = 11'd200;
            5'd7:       u = 11'd171;
            5'd8:       u = 11'd150;
            5'd9:       u = 11'd133;
            5'd10:      u = 11'd120;
            5'd11:      u = 11'd109;
            5'd12:      u = 11'd100;
            5'd13:      u = 11'd92;
            5'd14:      u = 11'd85;
            5'd15:      u = 11'd80;
            5'd16:      u = 11'd75;
            5'd17:      u = 11'd70;
            default:    u = 11'd66;
        endcase
        return u;
    endfunction

    // Folds upper case and looks the character up; zero means no code.
    function automatic logic [7:0] morse_code(input logic [CHAR_W-1:0] c_in);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] off_l;
        logic [CHAR_W-1:0] off_d;
        logic [7:0]        code;
        c = c_in;
        if (c >= 8'h41 && c <= 8'h5A) begin
            c = c + 8'h20;
        end
        off_l = c - 8'h61;
        off_d = c - 8'h30;
        if (c >= 8'h61 && c <= 8'h7A) begin
            code = LETTER_CODES[off_l[4:0]];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            code = DIGIT_CODES[off_d[3:0]];
        end else if (c == 8'h20) begin
            code = CODE_SPACE;
        end else if (c == 8'h23) begin
            code = CODE_HASH;
        end else if (c == 8'h40) begin
            code = CODE_AT;
        end else begin
            code = CODE_NONE;
        end
        return code;
    endfunction

endpackage

@@ hdl/morse_farnsworth_keyer.sv @@
// The first segment request is registered from the accepted character through the sequencer
// state and then the output register; after that, one segment per cycle while seg_ready stays high.
// The sequencer steps through every element of a character, the gap after each element but the
// last, and the closing gap (a word gap alone for a character without elements), and takes
// the next character only once it has returned to idle.
// Reset (rst_n low, asynchronous) idles the sequencer, empties the output and sets 9 / 18 wpm.
`timescale 1ns / 1ps
`include "morse_farnsworth_keyer_macros.svh"

module morse_farnsworth_keyer (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mfk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfk_pkg::WPM_W-1:0]     cfg_data,
    // Character channel.
    input  logic                          char_valid,
    output logic                          char_ready,
    input  logic [mfk_pkg::CHAR_W-1:0]    char_code,
    // Segment channel.
    output logic                          seg_valid,
    input  logic                          seg_ready,
    output logic                          key_on,
    output logic [mfk_pkg::DUR_W-1:0]     duration_ms,
    output logic                          unknown_char,
    output logic                          last
);

    import mfk_pkg::*;

    // The speed registers can be written at any time the port is offered a request;
    // the user only changes them while the keyer is idle.
    logic [WPM_W-1:0] overall_wpm_reg;
    logic [WPM_W-1:0] char_wpm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overall_wpm_reg <= OVERALL_WPM_RESET;
            char_wpm_reg    <= CHAR_WPM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_OVERALL_WPM)
            begin
                overall_wpm_reg <= cfg_data;
            end
            else if (cfg_index == REG_CHAR_WPM)
            begin
                char_wpm_reg <= cfg_data;
            end
        end
    end

    // Character decode at the input. The element bits, their count and the
    // unknown flag are captured with the timing units when a request is accepted.
    logic [7:0]        in_code;
    logic [2:0]        in_len;
    logic [UNIT_W-1:0] in_slow;
    logic [UNIT_W-1:0] in_fast_raw;
    logic [UNIT_W-1:0] in_fast;

    always_comb
    begin
        in_code     = morse_code(char_code);
        in_len      = (in_code[2:0] > MAX_ELEMS) ? MAX_ELEMS : in_code[2:0];
        in_slow     = unit_ms(overall_wpm_reg);
        in_fast_raw = unit_ms(char_wpm_reg);
        // Farnsworth spacing never lets the element unit be longer than the gap unit.
        in_fast     = (in_fast_raw > in_slow) ? in_slow : in_fast_raw;
    end

    seq_state_t        state_reg, state_next;
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        len_reg;
    logic [4:0]        elems_reg;
    logic              unknown_reg;
    logic [UNIT_W-1:0] slow_reg;
    logic [UNIT_W-1:0] fast_reg;

    logic accept;
    logic step;

    assign char_ready = (state_reg == ST_IDLE);
    assign accept     = char_valid && char_ready;
    // The sequencer moves on whenever the output register is free or being drained.
    assign step       = (state_reg != ST_IDLE) && (!seg_valid || seg_ready);

    // Next-state logic of the segment sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = 3'd0;
                if (accept)
                begin
                    state_next = (in_len == 3'd0) ? ST_TAIL : ST_ELEM;
                end
            end
            ST_ELEM:
            begin
                if (step)
                begin
                    state_next = ((idx_reg + 3'd1) < len_reg) ? ST_GAP : ST_TAIL;
                end
            end
            ST_GAP:
            begin
                if (step)
                begin
                    state_next = ST_ELEM;
                    idx_next   = idx_reg + 3'd1;
                end
            end
            ST_TAIL:
            begin
                if (step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode: what the current state asks of the shared scaling unit.
    logic   seg_key_on;
    logic   seg_last;
    logic   seg_unknown;
    logic   use_slow;
    scale_t scale_sel;

    always_comb
    begin
        seg_key_on  = 1'b0;
        seg_last    = 1'b0;
        seg_unknown = 1'b0;
        use_slow    = 1'b0;
        scale_sel   = SCALE_X1;
        case (state_reg)
            ST_ELEM:
            begin
                seg_key_on = 1'b1;
                scale_sel  = elems_reg[idx_reg] ? SCALE_X3 : SCALE_X1;
            end
            ST_GAP:
            begin
                scale_sel = SCALE_X1;
            end
            ST_TAIL:
            begin
                // A coded character closes with a character gap, anything else
                // is a single word gap.
                seg_last    = 1'b1;
                use_slow    = 1'b1;
                seg_unknown = (len_reg == 3'd0) && unknown_reg;
                scale_sel   = (len_reg == 3'd0) ? SCALE_X7 : SCALE_X3;
            end
            default:
            begin
                seg_key_on = 1'b0;
            end
        endcase
    end

    // Shared scaling unit: one unit times 1, 3 or 7 by shift and add or subtract.
    logic [DUR_W-1:0] unit_op;
    logic [DUR_W-1:0] scaled;

    always_comb
    begin
        unit_op = {{(DUR_W-UNIT_W){1'b0}}, (use_slow ? slow_reg : fast_reg)};
        case (scale_sel)
            SCALE_X1: scaled = unit_op;
            SCALE_X3: scaled = (unit_op << 1) + unit_op;
            SCALE_X7: scaled = (unit_op << 3) - unit_op;
            default:  scaled = unit_op;
        endcase
    end

    // Control registers.
    logic seg_valid_reg, seg_valid_next;

    always_comb
    begin
        if (step)
        begin
            seg_valid_next = 1'b1;
        end
        else if (seg_ready)
        begin
            seg_valid_next = 1'b0;
        end
        else
        begin
            seg_valid_next = seg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 3'd0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    // Per-character payload, captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg     <= in_len;
            elems_reg   <= in_code[7:3];
            unknown_reg <= (in_code == CODE_NONE) && (char_code != '0);
            slow_reg    <= in_slow;
            fast_reg    <= in_fast;
        end
    end

    // Output register.
    logic             key_on_reg;
    logic [DUR_W-1:0] duration_reg;
    logic             unknown_out_reg;
    logic             last_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            key_on_reg      <= seg_key_on;
            duration_reg    <= scaled;
            unknown_out_reg <= seg_unknown;
            last_reg        <= seg_last;
        end
    end

    assign seg_valid    = seg_valid_reg;
    assign key_on       = key_on_reg;
    assign duration_ms  = duration_reg;
    assign unknown_char = unknown_out_reg;
    assign last         = last_reg;

    // The closing segment of a character is always a key-up gap.
    `MFK_ASSERT_IMPLIES(a_last_is_gap, seg_valid && last, !key_on, "last segment has key down")
    // An unknown character only ever produces its single word gap.
    `MFK_ASSERT_IMPLIES(a_unknown_on_last, seg_valid && unknown_char, last, "unknown flag early")
    // A dash is the longest key-down segment: three units of at most 1200 ms.
    `MFK_ASSERT_IMPLIES(a_key_down_len, seg_valid && key_on, duration_ms <= 14'd3600,
        "key-down segment too long")
    // The element index stays inside the character while elements are sent.
    `MFK_ASSERT_IMPLIES(a_idx_range, state_reg == ST_ELEM || state_reg == ST_GAP,
        idx_reg < len_reg, "element index out of range")
    // A stalled segment must not be overwritten by the sequencer.
    `MFK_ASSERT_CLK(a_hold_on_stall, seg_valid && !seg_ready |=> $stable(duration_ms),
        "segment changed while stalled")

endmodule
